FILE: rtl/core/gemm_register_tile_kernel_macros.svh
// ----------------------------------------------------------------------------
// gemm register tile kernel assertion macros
// property shorthands for the tile kernel blocks, used by grtk_acc_tile
// ----------------------------------------------------------------------------
`ifndef GEMM_REGISTER_TILE_KERNEL_MACROS_SVH
`define GEMM_REGISTER_TILE_KERNEL_MACROS_SVH

// same-cycle implication
`define GRTK_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grtk: same-cycle check failed");

// next-cycle implication
`define GRTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grtk: next-cycle check failed");

`endif

FILE: rtl/core/grtk_pkg.sv
// ----------------------------------------------------------------------------
// grtk_pkg
// types and constants of the register tile gemm kernel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grtk_pkg;

    localparam int TILE_ROWS = 4;
    localparam int TILE_COLS = 8;
    localparam int TILE_SIZE = TILE_ROWS * TILE_COLS;
    localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

    localparam int LANE_W    = 16;
    localparam int LANES     = 4;
    localparam int PROD_W    = 2 * LANE_W;
    localparam int ACC_W     = 48;
    localparam int ACC_HALF  = ACC_W / 2;
    localparam int GAIN_W    = 16;
    localparam int C_W       = 32;
    localparam int ROW_IDX_W = 2;
    localparam int COL_IDX_W = 3;
    localparam int SUM_W     = 64;
    localparam int P_LO_W    = GAIN_W + ACC_HALF + 1;
    localparam int P_HI_W    = GAIN_W + ACC_W - ACC_HALF;
    localparam int P_BETA_W  = GAIN_W + C_W;
    localparam int C_ALIGN   = 6;
    localparam int ROUND_SHIFT = 18;

    localparam int IN_TDATA_W  = 3 * LANES * LANE_W + C_W;
    localparam int OUT_FIELD_W = C_W + ROW_IDX_W + COL_IDX_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam int CFG_IDX_W = 1;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd4096;
    localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [SUM_W-1:0]  SAT_MAX = SUM_W'(2147483647);
    // -2^31 as the complement of 2^31-1
    localparam logic signed [SUM_W-1:0]  SAT_MIN = ~SAT_MAX;

    typedef enum logic {
        CMD_ACC = 1'b0,
        CMD_WB  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 1'b0,
        CFG_BETA  = 1'b1
    } t_cfg_idx;

    // one write-back element on its way to the scale unit
    typedef struct packed {
        logic                 valid;
        logic [ACC_W-1:0]     acc;
        logic [C_W-1:0]       c_in;
        logic [ROW_IDX_W-1:0] row;
        logic [COL_IDX_W-1:0] col;
        logic                 last;
    } t_wb_req;

endpackage

`default_nettype wire

FILE: rtl/core/grtk_acc_tile.sv
// ----------------------------------------------------------------------------
// grtk_acc_tile
// tile accumulators, outer-product update and column-order write-back walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gemm_register_tile_kernel_macros.svh"

module grtk_acc_tile (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire grtk_pkg::t_cmd                        i_cmd,
    input  wire logic [grtk_pkg::LANES*grtk_pkg::LANE_W-1:0]   i_a_column,
    input  wire logic [2*grtk_pkg::LANES*grtk_pkg::LANE_W-1:0] i_b_row,
    input  wire logic [grtk_pkg::C_W-1:0]              i_c_in,
    output grtk_pkg::t_wb_req                          o_wb
);

    logic [grtk_pkg::ACC_W-1:0] r_acc [grtk_pkg::TILE_ROWS][grtk_pkg::TILE_COLS];
    logic [grtk_pkg::ROW_W-1:0] r_row;
    logic [grtk_pkg::COL_W-1:0] r_col;
    logic [grtk_pkg::ROW_W-1:0] n_row;
    logic [grtk_pkg::COL_W-1:0] n_col;
    logic                       w_last;
    logic signed [grtk_pkg::PROD_W-1:0] w_prod [grtk_pkg::TILE_ROWS][grtk_pkg::TILE_COLS];

    always_comb begin
        for (int i = 0; i < grtk_pkg::TILE_ROWS; i++) begin
            for (int j = 0; j < grtk_pkg::TILE_COLS; j++) begin
                w_prod[i][j] = $signed(i_a_column[i*grtk_pkg::LANE_W +: grtk_pkg::LANE_W])
                             * $signed(i_b_row[j*grtk_pkg::LANE_W +: grtk_pkg::LANE_W]);
            end
        end
    end

    // walk runs row fastest, then column
    assign w_last = (r_row == grtk_pkg::ROW_W'(grtk_pkg::TILE_ROWS - 1))
                 && (r_col == grtk_pkg::COL_W'(grtk_pkg::TILE_COLS - 1));

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_last) begin
            n_row = '0;
            n_col = '0;
        end else if (r_row == grtk_pkg::ROW_W'(grtk_pkg::TILE_ROWS - 1)) begin
            n_row = '0;
            n_col = r_col + 1'b1;
        end else begin
            n_row = r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            for (int i = 0; i < grtk_pkg::TILE_ROWS; i++) begin
                for (int j = 0; j < grtk_pkg::TILE_COLS; j++) begin
                    r_acc[i][j] <= '0;
                end
            end
        end else if (i_en && i_valid) begin
            if (i_cmd == grtk_pkg::CMD_ACC) begin
                for (int i = 0; i < grtk_pkg::TILE_ROWS; i++) begin
                    for (int j = 0; j < grtk_pkg::TILE_COLS; j++) begin
                        r_acc[i][j] <= r_acc[i][j] + grtk_pkg::ACC_W'(w_prod[i][j]);
                    end
                end
            end else begin
                r_row <= n_row;
                r_col <= n_col;
                if (w_last) begin
                    for (int i = 0; i < grtk_pkg::TILE_ROWS; i++) begin
                        for (int j = 0; j < grtk_pkg::TILE_COLS; j++) begin
                            r_acc[i][j] <= '0;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        o_wb.valid = i_valid && (i_cmd == grtk_pkg::CMD_WB);
        o_wb.acc   = r_acc[r_row][r_col];
        o_wb.c_in  = i_c_in;
        o_wb.row   = grtk_pkg::ROW_IDX_W'(r_row);
        o_wb.col   = grtk_pkg::COL_IDX_W'(r_col);
        o_wb.last  = w_last;
    end

    `GRTK_ASSERT_NEXT(a_last_wb_rewinds, i_clk, i_rst_n, i_en && o_wb.valid && w_last,
        (r_row == '0) && (r_col == '0))
    `GRTK_ASSERT_NEXT(a_last_wb_clears, i_clk, i_rst_n, i_en && o_wb.valid && w_last,
        (r_acc[0][0] == '0)
        && (r_acc[grtk_pkg::TILE_ROWS-1][grtk_pkg::TILE_COLS-1] == '0))
    `GRTK_ASSERT_NEXT(a_acc_keeps_walk, i_clk, i_rst_n,
        i_en && i_valid && (i_cmd == grtk_pkg::CMD_ACC), $stable(r_row) && $stable(r_col))

endmodule

`default_nettype wire

FILE: rtl/core/grtk_scale_unit.sv
// ----------------------------------------------------------------------------
// grtk_scale_unit
// alpha/beta scaling, rounding to q8.24 and saturation into the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grtk_scale_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire grtk_pkg::t_wb_req                 i_wb,
    input  wire logic [grtk_pkg::GAIN_W-1:0]       i_alpha,
    input  wire logic [grtk_pkg::GAIN_W-1:0]       i_beta,
    output logic                                   o_valid,
    output logic [grtk_pkg::C_W-1:0]               o_c_out,
    output logic [grtk_pkg::ROW_IDX_W-1:0]         o_row,
    output logic [grtk_pkg::COL_IDX_W-1:0]         o_col,
    output logic                                   o_last
);

    // product stage
    logic                                   r_s2_valid;
    logic signed [grtk_pkg::P_LO_W-1:0]     r_p_lo;
    logic signed [grtk_pkg::P_HI_W-1:0]     r_p_hi;
    logic signed [grtk_pkg::P_BETA_W-1:0]   r_p_beta;
    logic [grtk_pkg::ROW_IDX_W-1:0]         r_s2_row;
    logic [grtk_pkg::COL_IDX_W-1:0]         r_s2_col;
    logic                                   r_s2_last;
    logic signed [grtk_pkg::P_LO_W-1:0]     n_p_lo;
    logic signed [grtk_pkg::P_HI_W-1:0]     n_p_hi;
    logic signed [grtk_pkg::P_BETA_W-1:0]   n_p_beta;

    // result stage
    logic                                   r_out_valid;
    logic [grtk_pkg::C_W-1:0]               r_c_out;
    logic [grtk_pkg::ROW_IDX_W-1:0]         r_row;
    logic [grtk_pkg::COL_IDX_W-1:0]         r_col;
    logic                                   r_last;
    logic signed [grtk_pkg::SUM_W-1:0]      n_sum;
    logic signed [grtk_pkg::SUM_W-1:0]      n_res;
    logic [grtk_pkg::C_W-1:0]               n_c_out;

    // alpha*acc split into two halves of the accumulator
    always_comb begin
        n_p_lo = $signed(i_alpha) * $signed({1'b0, i_wb.acc[grtk_pkg::ACC_HALF-1:0]});
        n_p_hi = $signed(i_alpha) * $signed(i_wb.acc[grtk_pkg::ACC_W-1:grtk_pkg::ACC_HALF]);
        if (i_beta == '0) begin
            n_p_beta = '0;
        end else begin
            n_p_beta = $signed(i_beta) * $signed(i_wb.c_in);
        end
    end

    always_comb begin
        n_sum = (grtk_pkg::SUM_W'(r_p_hi) <<< grtk_pkg::ACC_HALF)
              + grtk_pkg::SUM_W'(r_p_lo)
              + (grtk_pkg::SUM_W'(r_p_beta) <<< grtk_pkg::C_ALIGN)
              + grtk_pkg::ROUND_BIAS;
        n_res = n_sum >>> grtk_pkg::ROUND_SHIFT;
        if (n_res > grtk_pkg::SAT_MAX) begin
            n_c_out = grtk_pkg::C_W'(grtk_pkg::SAT_MAX);
        end else if (n_res < grtk_pkg::SAT_MIN) begin
            n_c_out = grtk_pkg::C_W'(grtk_pkg::SAT_MIN);
        end else begin
            n_c_out = n_res[grtk_pkg::C_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid  <= i_wb.valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo    <= n_p_lo;
            r_p_hi    <= n_p_hi;
            r_p_beta  <= n_p_beta;
            r_s2_row  <= i_wb.row;
            r_s2_col  <= i_wb.col;
            r_s2_last <= i_wb.last;
            r_c_out   <= n_c_out;
            r_row     <= r_s2_row;
            r_col     <= r_s2_col;
            r_last    <= r_s2_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_c_out = r_c_out;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_last  = r_last;

endmodule

`default_nettype wire

FILE: rtl/core/gemm_register_tile_kernel.sv
// ----------------------------------------------------------------------------
// gemm_register_tile_kernel
// 4x8 register-tile gemm kernel: outer-product accumulate and scaled write-back
// ----------------------------------------------------------------------------
//  channel  | direction | beat carries
//  s        | in        | tuser: command; tdata: a_column, b_row_low, b_row_high, c_in
//  m        | out       | tdata: c_out, row_index, col_index, pad; tlast: last
//  cfg      | in        | register index and write data, no handshake
//
//  one beat is taken per cycle while o_s_tready is high, accumulate or write-back alike
//  a write-back beat passes in order through the input register, the product
//  register (two 16x24 multiplies plus beta*c) and the result register
//  the three stages advance together; they stop only while the result register
//  holds a beat that the sink does not take
//  synchronous reset clears the accumulators, the walk and the gains to 1.0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gemm_register_tile_kernel (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [grtk_pkg::IN_TDATA_W-1:0]      i_s_tdata,  // a_column, b_row_low, b_row_high, c_in
    input  wire logic                                 i_s_tuser,  // command
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [grtk_pkg::OUT_TDATA_W-1:0]          o_m_tdata,  // c_out, row_index, col_index, zero pad
    output logic                                      o_m_tlast,
    input  wire logic                                 i_cfg_we,
    input  wire logic [grtk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [grtk_pkg::GAIN_W-1:0]          i_cfg_data
);

    localparam int AB_W = grtk_pkg::LANES * grtk_pkg::LANE_W;

    logic                              w_en;
    logic                              r_s1_valid;
    grtk_pkg::t_cmd                    r_s1_cmd;
    logic [AB_W-1:0]                   r_s1_a;
    logic [2*AB_W-1:0]                 r_s1_b;
    logic [grtk_pkg::C_W-1:0]          r_s1_c;
    logic [grtk_pkg::GAIN_W-1:0]       r_alpha;
    logic [grtk_pkg::GAIN_W-1:0]       r_beta;
    grtk_pkg::t_wb_req                 w_wb;
    logic [grtk_pkg::C_W-1:0]          w_c_out;
    logic [grtk_pkg::ROW_IDX_W-1:0]    w_row;
    logic [grtk_pkg::COL_IDX_W-1:0]    w_col;

    // pipeline moves unless a result sits unclaimed
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= grtk_pkg::GAIN_ONE;
            r_beta  <= grtk_pkg::GAIN_ONE;
        end else if (i_cfg_we) begin
            unique case (grtk_pkg::t_cfg_idx'(i_cfg_index))
                grtk_pkg::CFG_ALPHA: r_alpha <= i_cfg_data;
                grtk_pkg::CFG_BETA:  r_beta  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_s_tvalid) begin
            r_s1_cmd <= grtk_pkg::t_cmd'(i_s_tuser);
            r_s1_a   <= i_s_tdata[AB_W-1:0];
            r_s1_b   <= i_s_tdata[3*AB_W-1:AB_W];
            r_s1_c   <= i_s_tdata[3*AB_W +: grtk_pkg::C_W];
        end
    end

    grtk_acc_tile u_acc_tile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s1_valid),
        .i_cmd      (r_s1_cmd),
        .i_a_column (r_s1_a),
        .i_b_row    (r_s1_b),
        .i_c_in     (r_s1_c),
        .o_wb       (w_wb)
    );

    grtk_scale_unit u_scale_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_wb    (w_wb),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .o_valid (o_m_tvalid),
        .o_c_out (w_c_out),
        .o_row   (w_row),
        .o_col   (w_col),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {{grtk_pkg::OUT_PAD_W{1'b0}}, w_col, w_row, w_c_out};

endmodule

`default_nettype wire
